// File: src/dhkt_pkg.sv
`default_nettype none
package dhkt_pkg;
    localparam int TableBits = 16;
    localparam int EntryBits = 14;
    localparam int KeyBits = 64;
    localparam int DepthBits = 16;
    localparam int CopyBits = 2;
    localparam logic [DepthBits-1:0] DepthMax = '1;
    localparam logic [CopyBits-1:0] CopyMax = 2'd3;

    localparam logic [1:0] ACT_FIND = 2'd0;
    localparam logic [1:0] ACT_ADD = 2'd1;
    localparam logic [1:0] ACT_MERGE = 2'd2;
    // unused code, acts as find
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NEW = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic                 adding;
        logic                 merging;
        logic [KeyBits-1:0]   key;
        logic [DepthBits-1:0] add_depth;
        logic [CopyBits-1:0]  add_copy;
    } dhkt_cmd_t;

    typedef struct packed {
        logic [EntryBits-1:0] entry_number;
        logic [DepthBits-1:0] depth_now;
        logic [CopyBits-1:0]  copy_now;
        logic [1:0]           status;
    } dhkt_res_t;
endpackage
`default_nettype wire

// File: src/dhkt_front.sv
`default_nettype none
module dhkt_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              action,
    input  wire logic [63:0]             key,
    input  wire logic [15:0]             add_depth,
    input  wire logic [1:0]              add_copy,
    output dhkt_pkg::dhkt_cmd_t          cmd,
    output logic                         cmd_valid,
    input  wire logic                    cmd_pop
);
    import dhkt_pkg::*;

    // two-entry queue of classified items
    dhkt_cmd_t q_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    dhkt_cmd_t  c;
    logic       push;

    // classify the action code; unused code acts as find
    always_comb
    begin
        c.adding    = (action == ACT_ADD) || (action == ACT_MERGE);
        c.merging   = (action == ACT_MERGE);
        c.key       = key;
        c.add_depth = add_depth;
        c.add_copy  = add_copy;
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (cmd_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end
endmodule
`default_nettype wire

// File: src/dhkt_back.sv
`default_nettype none
module dhkt_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [13:0]             entry_limit,
    input  wire dhkt_pkg::dhkt_cmd_t     cmd,
    input  wire logic                    cmd_valid,
    output logic                         cmd_pop,
    output dhkt_pkg::dhkt_res_t          res,
    output logic                         res_valid,
    input  wire logic                    res_stall
);
    import dhkt_pkg::*;

    localparam int SlotCount = 1 << TableBits;
    localparam int EntryCount = 1 << EntryBits;
    localparam logic [TableBits:0] SlotCountW = (TableBits+1)'(SlotCount);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SLOT, S_KEY, S_DECIDE, S_MERGE, S_OUT
    } state_t;

    // stores
    logic [EntryBits-1:0] slot_mem  [SlotCount];
    logic [KeyBits-1:0]   key_mem   [EntryCount];
    logic [DepthBits-1:0] depth_mem [EntryCount];
    logic [CopyBits-1:0]  copy_mem  [EntryCount];

    state_t               state_reg;
    dhkt_cmd_t            cmd_reg;
    logic [TableBits-1:0] off_reg, step_reg;
    logic [TableBits:0]   n_reg;
    logic [TableBits-1:0] clr_reg;
    logic [EntryBits-1:0] slot_rd_reg, ent_reg, count_reg;
    logic [KeyBits-1:0]   key_rd_reg;
    logic [DepthBits-1:0] depth_rd_reg;
    logic [CopyBits-1:0]  copy_rd_reg;
    logic                 empty_reg;
    dhkt_res_t            res_reg;
    logic                 res_valid_reg;

    // memory write controls
    logic                 slot_we, ent_we, merge_we;
    logic [TableBits-1:0] slot_wa;
    logic [EntryBits-1:0] slot_wd, ent_wa;
    logic [DepthBits-1:0] dep_wd;
    logic [CopyBits-1:0]  cp_wd;
    logic [DepthBits:0]   dsum;
    logic [CopyBits:0]    csum;
    logic [EntryBits-1:0] new_ent;
    logic                 insert;

    assign dsum    = {1'b0, depth_rd_reg} + {1'b0, cmd_reg.add_depth};
    assign csum    = {1'b0, copy_rd_reg} + {1'b0, cmd_reg.add_copy};
    assign new_ent = count_reg + 1'b1;
    assign dep_wd  = dsum[DepthBits] ? DepthMax : dsum[DepthBits-1:0];
    assign cp_wd   = csum[CopyBits] ? CopyMax : csum[CopyBits-1:0];

    // absent key with a free slot and room below the limit
    assign insert  = (state_reg == S_DECIDE) && ent_reg == '0 && cmd_reg.adding && empty_reg
                     && ({1'b0, new_ent} < {1'b0, entry_limit}) && new_ent != '0;

    always_comb
    begin
        slot_we  = 1'b0;
        slot_wa  = off_reg;
        slot_wd  = new_ent;
        ent_we   = 1'b0;
        merge_we = 1'b0;
        ent_wa   = ent_reg;
        if (state_reg == S_CLEAR)
        begin
            slot_we = 1'b1;
            slot_wa = clr_reg;
            slot_wd = '0;
            ent_we  = 1'b1;
            ent_wa  = clr_reg[EntryBits-1:0];
        end
        else if (insert)
        begin
            slot_we = 1'b1;
        end
        else if (state_reg == S_MERGE)
        begin
            merge_we = cmd_reg.merging;
        end
    end

    // slot store
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[off_reg];
    end

    // key store, written on insert
    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            key_mem[new_ent] <= cmd_reg.key;
        end
        key_rd_reg <= key_mem[slot_rd_reg];
    end

    // depth and copy stores
    always_ff @(posedge clk)
    begin
        if (ent_we || merge_we)
        begin
            depth_mem[ent_wa] <= ent_we ? '0 : dep_wd;
            copy_mem[ent_wa]  <= ent_we ? '0 : cp_wd;
        end
        depth_rd_reg <= depth_mem[ent_reg];
        copy_rd_reg  <= copy_mem[ent_reg];
    end

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid && !res_valid_reg;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // probe sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            cmd_reg       <= '0;
            off_reg       <= '0;
            step_reg      <= '0;
            n_reg         <= '0;
            ent_reg       <= '0;
            empty_reg     <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        cmd_reg   <= cmd;
                        off_reg   <= cmd.key[TableBits-1:0];
                        step_reg  <= cmd.key[2*TableBits-1:TableBits] | 1'b1;
                        n_reg     <= '0;
                        ent_reg   <= '0;
                        empty_reg <= 1'b0;
                        state_reg <= S_SLOT;
                    end
                end
                S_SLOT:
                begin
                    // slot read lands next cycle
                    state_reg <= S_KEY;
                end
                S_KEY:
                begin
                    if (slot_rd_reg == '0)
                    begin
                        empty_reg <= 1'b1;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // compare key of occupied slot
                    if (key_rd_reg == cmd_reg.key)
                    begin
                        ent_reg   <= slot_rd_reg;
                        state_reg <= S_DECIDE;
                    end
                    else if (n_reg + 1'b1 == SlotCountW)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        off_reg   <= off_reg + step_reg;
                        state_reg <= S_SLOT;
                    end
                end
                S_DECIDE:
                begin
                    if (ent_reg != '0)
                    begin
                        res_reg.status <= ST_FOUND;
                        state_reg      <= S_MERGE;
                    end
                    else if (!cmd_reg.adding)
                    begin
                        res_reg        <= '0;
                        res_reg.status <= ST_MISS;
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else if (!empty_reg || !({1'b0, new_ent} < {1'b0, entry_limit})
                             || new_ent == '0)
                    begin
                        res_reg        <= '0;
                        res_reg.status <= ST_FULL;
                        res_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        count_reg      <= new_ent;
                        ent_reg        <= new_ent;
                        res_reg.status <= ST_NEW;
                        state_reg      <= S_MERGE;
                    end
                end
                S_MERGE:
                begin
                    // depth and copy of a found entry are registered now; for a new entry they read as zero
                    res_reg.entry_number <= ent_reg;
                    res_reg.depth_now    <= cmd_reg.merging ? dep_wd : depth_rd_reg;
                    res_reg.copy_now     <= cmd_reg.merging ? cp_wd : copy_rd_reg;
                    res_valid_reg        <= 1'b1;
                    state_reg            <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/double_hash_key_table.sv
// flow: each probe is the slot state, the key state and, for an occupied slot, a
// key compare; a hit or an insert then passes decide and merge before the result
// throughput: one item at a time; the next item starts the cycle after the
// previous result is taken; each probe is a slot read then a key read
// reset: slot, depth and copy stores are cleared by a pass over all 65536 slots
// after reset; items wait during it, configuration writes are taken at once
`default_nettype none
module double_hash_key_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [13:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] key,
    input  wire logic [15:0] add_depth,
    input  wire logic [1:0]  add_copy,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [13:0]      entry_number,
    output logic [15:0]      depth_now,
    output logic [1:0]       copy_now,
    output logic [1:0]       status
);
    import dhkt_pkg::*;

    logic [13:0] limit_reg;
    dhkt_cmd_t   cmd;
    logic        cmd_valid, cmd_pop;
    dhkt_res_t   res;

    // entry limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 14'd16383;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    dhkt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .key(key), .add_depth(add_depth), .add_copy(add_copy),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
    );

    dhkt_back u_back (
        .clk(clk), .rst_n(rst_n), .entry_limit(limit_reg), .cmd(cmd),
        .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .res(res),
        .res_valid(out_valid), .res_stall(out_stall)
    );

    assign entry_number = res.entry_number;
    assign depth_now    = res.depth_now;
    assign copy_now     = res.copy_now;
    assign status       = res.status;
endmodule
`default_nettype wire

// File: src/dhkt_checker.sv
`default_nettype none
module dhkt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [13:0] entry_number,
    input wire logic [15:0] depth_now,
    input wire logic [1:0]  copy_now,
    input wire logic [1:0]  status
);
    import dhkt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status))
        else $error("stalled result dropped");
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_MISS || status == ST_FULL) |->
        entry_number == '0 && depth_now == '0 && copy_now == '0)
        else $error("miss carries data");
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FOUND || status == ST_NEW) |-> entry_number != '0)
        else $error("hit without entry");
endmodule

bind double_hash_key_table dhkt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .entry_number(entry_number), .depth_now(depth_now), .copy_now(copy_now),
    .status(status)
);
`default_nettype wire
